@@ rtl/core/dss_pkg.sv @@
// ----------------------------------------------------------------------------
// dss_pkg
// Shared constants for the disk seek scheduler: table size, codes, widths.
// ----------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

	// request table
	localparam int QUEUE_DEPTH = 32;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// field widths
	localparam int TRK_W  = 10;
	localparam int PID_W  = 16;
	localparam int TOT_W  = 16;
	localparam int ENT_W  = TRK_W + PID_W;

	// input op codes
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// service modes
	localparam logic [1:0] MODE_FCFS = 2'd0;
	localparam logic [1:0] MODE_SSTF = 2'd1;
	localparam logic [1:0] MODE_SCAN = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_HEAD = 2'd1;
	localparam logic [1:0] CFG_LAST = 2'd2;

	// result status codes
	localparam logic [2:0] ST_DONE    = 3'd0;
	localparam logic [2:0] ST_BAD_TRK = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_SERVICE = 3'd4;

	// reset value of the last-track register
	localparam logic [TRK_W-1:0] LAST_TRACK_RST = 10'd199;

endpackage

`default_nettype wire

@@ rtl/core/dss_ifs.sv @@
// ----------------------------------------------------------------------------
// dss_ifs
// Valid/ready channels of the disk seek scheduler: request and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface dss_req_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               op;
	logic [dss_pkg::TRK_W-1:0] track;
	logic [dss_pkg::PID_W-1:0] process_id;

	modport source (output valid, output op, output track, output process_id, input ready);
	modport sink   (input valid, input op, input track, input process_id, output ready);
endinterface

interface dss_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [2:0]               status;
	logic [dss_pkg::TRK_W-1:0] served_track;
	logic [dss_pkg::PID_W-1:0] served_process;
	logic [dss_pkg::TRK_W-1:0] move_distance;
	logic [dss_pkg::TOT_W-1:0] total_distance;
	logic                     last;

	modport source (output valid, output status, output served_track, output served_process,
		output move_distance, output total_distance, output last, input ready);
	modport sink   (input valid, input status, input served_track, input served_process,
		input move_distance, input total_distance, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dss_ram.sv @@
// ----------------------------------------------------------------------------
// dss_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/core/disk_seek_scheduler.sv @@
// ----------------------------------------------------------------------------
// disk_seek_scheduler
// Table of pending seek requests with FCFS, SSTF and SCAN (LOOK) service order.
// ----------------------------------------------------------------------------
// Usage:
//   req  : request words (op, track, process_id), valid/ready.
//   rsp  : result words, valid/ready, one output register.
//   cfg  : write port for mode, head_position and last_track; write only
//          while the block is idle.
//   Add, clear and unknown ops give one result word, shown in the cycle
//   after the request word is taken.
//   A run over n stored requests gives n words. Every word needs one sweep
//   of the request RAM, n reads through the single read port of the table
//   RAM. An empty table gives one word at once.
//   A run leaves the table and the configured head untouched.
//   Reset empties the table and loads mode 0, head 0 and last track 199;
//   the table RAM itself needs no clearing.
//   When rsp stalls, the result stays in the output register and the
//   sweep waits before writing the next one; no request word is taken
//   while a run is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_seek_scheduler (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	dss_req_if.sink                        req,
	dss_rsp_if.source                      rsp,
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [dss_pkg::TRK_W-1:0] cfg_data
);

	localparam int IDX_W = dss_pkg::IDX_W;
	localparam int CNT_W = dss_pkg::CNT_W;
	localparam int TRK_W = dss_pkg::TRK_W;
	localparam int PID_W = dss_pkg::PID_W;
	localparam int TOT_W = dss_pkg::TOT_W;
	localparam int ENT_W = dss_pkg::ENT_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	function automatic logic [TRK_W-1:0] trk_gap(input logic [TRK_W-1:0] a,
		input logic [TRK_W-1:0] b);
		trk_gap = (a > b) ? (a - b) : (b - a);
	endfunction

	// configuration
	logic [1:0]       mode_q;
	logic [TRK_W-1:0] head_pos_q;
	logic [TRK_W-1:0] last_trk_q;

	// control
	logic [1:0]                   state_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             step_q;
	logic [CNT_W-1:0]             rd_idx_q;
	logic                         rd_on_q;
	logic                         rd_vld_s1;
	logic [IDX_W-1:0]             idx_s1;
	logic [dss_pkg::QUEUE_DEPTH-1:0] served_q;
	logic [TRK_W-1:0]             head_q;
	logic [TOT_W-1:0]             total_q;

	// best candidate of the current sweep
	logic                         have_q;
	logic [IDX_W-1:0]             best_idx_q;
	logic [TRK_W-1:0]             best_trk_q;
	logic [PID_W-1:0]             best_pid_q;

	// output register
	logic                         out_vld_q;
	logic [2:0]                   out_st_q;
	logic [TRK_W-1:0]             out_trk_q;
	logic [PID_W-1:0]             out_pid_q;
	logic [TRK_W-1:0]             out_mv_q;
	logic [TOT_W-1:0]             out_tot_q;
	logic                         out_last_q;

	logic             slot_free;
	logic             req_acc;
	logic             ram_we;
	logic [ENT_W-1:0] rdata;
	logic [TRK_W-1:0] rd_trk;
	logic [PID_W-1:0] rd_pid;
	logic [TRK_W-1:0] cand_d;
	logic [TRK_W-1:0] best_d;
	logic             cand_up;
	logic             best_up;
	logic             better;
	logic [TRK_W-1:0] emit_d;

	assign slot_free = !out_vld_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && slot_free;
	assign req_acc   = req.valid && req.ready;

	// table write on an accepted add with a legal track and a free slot
	assign ram_we = req_acc && (req.op == dss_pkg::OP_ADD) && (req.track <= last_trk_q)
		&& (count_q < CNT_W'(dss_pkg::QUEUE_DEPTH));

	dss_ram #(
		.WIDTH (ENT_W),
		.DEPTH (dss_pkg::QUEUE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata ({req.track, req.process_id}),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	assign rd_trk = rdata[ENT_W-1:PID_W];
	assign rd_pid = rdata[PID_W-1:0];

	// candidate compare against the sweep's best
	always_comb begin
		cand_d  = trk_gap(rd_trk, head_q);
		best_d  = trk_gap(best_trk_q, head_q);
		cand_up = rd_trk >= head_pos_q;
		best_up = best_trk_q >= head_pos_q;
		unique case (mode_q)
			dss_pkg::MODE_SSTF: better = !have_q || (cand_d < best_d);
			dss_pkg::MODE_SCAN: better = !have_q || (cand_up && !best_up)
				|| (cand_up && best_up && (rd_trk < best_trk_q))
				|| (!cand_up && !best_up && (rd_trk >= best_trk_q));
			default:            better = !have_q;
		endcase
	end

	assign emit_d = trk_gap(best_trk_q, head_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= dss_pkg::MODE_FCFS;
			head_pos_q <= '0;
			last_trk_q <= dss_pkg::LAST_TRACK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dss_pkg::CFG_MODE: mode_q <= cfg_data[1:0];
				dss_pkg::CFG_HEAD: begin
					if (cfg_data <= last_trk_q) begin
						head_pos_q <= cfg_data;
					end
				end
				dss_pkg::CFG_LAST: last_trk_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: table bookkeeping, sweeps and result words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			step_q    <= '0;
			rd_idx_q  <= '0;
			rd_on_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
			idx_s1    <= '0;
			served_q  <= '0;
			have_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						out_vld_q  <= 1'b1;
						out_st_q   <= dss_pkg::ST_DONE;
						out_trk_q  <= '0;
						out_pid_q  <= '0;
						out_mv_q   <= '0;
						out_tot_q  <= '0;
						out_last_q <= 1'b1;
						unique case (req.op)
							dss_pkg::OP_ADD: begin
								if (req.track > last_trk_q) begin
									out_st_q <= dss_pkg::ST_BAD_TRK;
								end else if (!ram_we) begin
									out_st_q <= dss_pkg::ST_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							dss_pkg::OP_CLEAR: count_q <= '0;
							dss_pkg::OP_RUN: begin
								if (count_q == '0) begin
									out_st_q <= dss_pkg::ST_EMPTY;
								end else begin
									out_vld_q <= 1'b0;
									served_q  <= '0;
									head_q    <= head_pos_q;
									total_q   <= '0;
									step_q    <= '0;
									rd_idx_q  <= '0;
									rd_on_q   <= 1'b1;
									have_q    <= 1'b0;
									state_q   <= S_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					// issue one read a cycle
					rd_vld_s1 <= rd_on_q;
					idx_s1    <= rd_idx_q[IDX_W-1:0];
					if (rd_on_q) begin
						if (rd_idx_q == count_q - CNT_W'(1)) begin
							rd_on_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + CNT_W'(1);
						end
					end
					// fold returned entry into the best candidate
					if (rd_vld_s1) begin
						if (!served_q[idx_s1] && better) begin
							have_q     <= 1'b1;
							best_idx_q <= idx_s1;
							best_trk_q <= rd_trk;
							best_pid_q <= rd_pid;
						end
						if ({1'b0, idx_s1} == count_q - CNT_W'(1)) begin
							rd_vld_s1 <= 1'b0;
							state_q   <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						out_vld_q            <= 1'b1;
						out_st_q             <= dss_pkg::ST_SERVICE;
						out_trk_q            <= best_trk_q;
						out_pid_q            <= best_pid_q;
						out_mv_q             <= emit_d;
						out_tot_q            <= total_q + TOT_W'(emit_d);
						out_last_q           <= (step_q == count_q - CNT_W'(1));
						total_q              <= total_q + TOT_W'(emit_d);
						head_q               <= best_trk_q;
						served_q[best_idx_q] <= 1'b1;
						step_q               <= step_q + CNT_W'(1);
						have_q               <= 1'b0;
						rd_idx_q             <= '0;
						if (step_q == count_q - CNT_W'(1)) begin
							state_q <= S_IDLE;
						end else begin
							rd_on_q <= 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result word
	assign rsp.valid          = out_vld_q;
	assign rsp.status         = out_st_q;
	assign rsp.served_track   = out_trk_q;
	assign rsp.served_process = out_pid_q;
	assign rsp.move_distance  = out_mv_q;
	assign rsp.total_distance = out_tot_q;
	assign rsp.last           = out_last_q;

endmodule

`default_nettype wire

@@ tb/sv/tb_disk_seek_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_disk_seek_scheduler
// Drives add, run, clear and unknown op words into the seek scheduler and checks every
// result word against an in-bench model of the table and its service orders.
// ----------------------------------------------------------------------------

import dss_pkg::*;

typedef struct packed {
	logic [2:0]       status;
	logic [TRK_W-1:0] trk;
	logic [PID_W-1:0] pid;
	logic [TRK_W-1:0] mv;
	logic [TOT_W-1:0] tot;
	logic             lst;
} seek_result_t;

// table model and queue of expected result words
class seek_scoreboard;
	logic [1:0]       mode_r;
	logic [TRK_W-1:0] head_r;
	logic [TRK_W-1:0] last_r;
	logic [TRK_W-1:0] trk_tab[QUEUE_DEPTH];
	logic [PID_W-1:0] pid_tab[QUEUE_DEPTH];
	int               count;
	seek_result_t     pending[$];
	int               errors;
	int               checked;
	int               service_words;

	function new();
		mode_r = MODE_FCFS;
		head_r = '0;
		last_r = LAST_TRACK_RST;
		count  = 0;
		errors = 0;
		checked = 0;
		service_words = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [TRK_W-1:0] data);
		if (idx == CFG_MODE)
			mode_r = data[1:0];
		else if (idx == CFG_HEAD) begin
			if (data <= last_r)
				head_r = data;
		end else if (idx == CFG_LAST)
			last_r = data;
	endfunction

	function int distance(int a, int b);
		return (a > b) ? a - b : b - a;
	endfunction

	// append one expected word
	function void add_expected(seek_result_t r);
		pending.insert(pending.size(), r);
	endfunction

	function void note_request(logic [1:0] op, logic [TRK_W-1:0] trk, logic [PID_W-1:0] pid);
		seek_result_t r;
		int order[$];
		int sorted[$];
		bit marked[QUEUE_DEPTH];
		int best, bi, d, head, total, split, pos;
		r = '0;
		r.lst = 1'b1;
		if (op == OP_ADD) begin
			if (trk > last_r)
				r.status = ST_BAD_TRK;
			else if (count >= QUEUE_DEPTH)
				r.status = ST_FULL;
			else begin
				trk_tab[count] = trk;
				pid_tab[count] = pid;
				count++;
				r.status = ST_DONE;
			end
			add_expected(r);
			return;
		end
		if (op != OP_RUN) begin
			if (op == OP_CLEAR)
				count = 0;
			r.status = ST_DONE;
			add_expected(r);
			return;
		end
		if (count == 0) begin
			r.status = ST_EMPTY;
			add_expected(r);
			return;
		end
		head = head_r;
		if (mode_r == MODE_SSTF) begin
			foreach (marked[i])
				marked[i] = 0;
			for (int k = 0; k < count; k++) begin
				best = 9999;
				bi = 0;
				for (int i = 0; i < count; i++) begin
					if (!marked[i]) begin
						d = distance(trk_tab[i], head);
						if (d < best) begin
							best = d;
							bi = i;
						end
					end
				end
				marked[bi] = 1;
				order.insert(order.size(), bi);
				head = trk_tab[bi];
			end
		end else if (mode_r == MODE_SCAN) begin
			// stable insertion by track
			for (int i = 0; i < count; i++) begin
				pos = sorted.size();
				while (pos > 0 && trk_tab[sorted[pos-1]] > trk_tab[i])
					pos--;
				sorted.insert(pos, i);
			end
			split = 0;
			while (split < count && trk_tab[sorted[split]] < head)
				split++;
			for (int i = split; i < count; i++)
				order.insert(order.size(), sorted[i]);
			for (int i = split; i > 0; i--)
				order.insert(order.size(), sorted[i-1]);
		end else begin
			for (int i = 0; i < count; i++)
				order.insert(order.size(), i);
		end
		head = head_r;
		total = 0;
		for (int k = 0; k < count; k++) begin
			d = distance(trk_tab[order[k]], head);
			total += d;
			head = trk_tab[order[k]];
			r.status = ST_SERVICE;
			r.trk = TRK_W'(head);
			r.pid = pid_tab[order[k]];
			r.mv = TRK_W'(d);
			r.tot = TOT_W'(total);
			r.lst = (k == count - 1);
			add_expected(r);
		end
	endfunction

	function void check_result(seek_result_t act);
		seek_result_t e;
		checked++;
		if (pending.size() == 0) begin
			errors++;
			$display("%0t: unexpected word, actual %p", $time, act);
			return;
		end
		e = pending.pop_front();
		if (act.status == ST_SERVICE)
			service_words++;
		if (act.status !== e.status || act.trk !== e.trk || act.pid !== e.pid ||
			act.mv !== e.mv || act.tot !== e.tot || act.lst !== e.lst) begin
			errors++;
			$display("%0t: mismatch, expected %p, actual %p", $time, e, act);
		end
	endfunction
endclass

module tb_disk_seek_scheduler;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [TRK_W-1:0] cfg_data;

	dss_req_if req ();
	dss_rsp_if rsp ();

	disk_seek_scheduler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req.sink),
		.rsp       (rsp.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	seek_scoreboard sb;
	bit  idle_on;
	int  hold_cycles;
	int  words_sent;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// result side: random stalls, one long hold-off on request
	initial begin
		int gap;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				rsp.ready <= 1'b0;
				hold_cycles--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 12);
				rsp.ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else
				rsp.ready <= 1'b1;
		end
	end

	// sample accepted result words
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result({rsp.status, rsp.served_track, rsp.served_process,
				rsp.move_distance, rsp.total_distance, rsp.last});
	end

	task automatic send_word(logic [1:0] op, logic [TRK_W-1:0] trk, logic [PID_W-1:0] pid);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 12);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.op         <= op;
		req.track      <= trk;
		req.process_id <= pid;
		do @(posedge clk); while (!req.ready);
		sb.note_request(op, trk, pid);
		words_sent++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// one register write, after which the write enable goes low again
	task automatic write_reg(logic [1:0] idx, logic [TRK_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	// a well-formed batch: clear, fill with mostly legal tracks, run
	task automatic batch(int n);
		logic [TRK_W-1:0] t;
		send_word(OP_CLEAR, TRK_W'($urandom), PID_W'($urandom));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				t = TRK_W'($urandom);
			else
				t = TRK_W'($urandom_range(0, sb.last_r));
			send_word(OP_ADD, t, PID_W'($urandom));
		end
		send_word(OP_RUN, TRK_W'($urandom), PID_W'($urandom));
	endtask

	task automatic pick_config();
		write_reg(CFG_MODE, TRK_W'($urandom_range(0, 3)));
		case ($urandom_range(0, 3))
			0: write_reg(CFG_LAST, 10'd1023);
			1: write_reg(CFG_LAST, 10'd0);
			default: write_reg(CFG_LAST, TRK_W'($urandom));
		endcase
		write_reg(CFG_HEAD, TRK_W'($urandom));
		write_reg(CFG_HEAD, TRK_W'($urandom_range(0, sb.last_r)));
	endtask

	initial begin
		sb = new();
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_MODE;
		cfg_data    = '0;
		req.valid   = 1'b0;
		req.op      = OP_ADD;
		req.track   = '0;
		req.process_id = '0;
		idle_on     = 1'b0;
		hold_cycles = 0;
		words_sent  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty run, extremes, invalid track, unknown op
		send_word(OP_RUN, 10'd0, 16'd0);
		send_word(OP_ADD, 10'd0, 16'hFFFF);
		send_word(OP_ADD, 10'd199, 16'h0000);
		send_word(OP_ADD, 10'd200, 16'h1234);
		send_word(OP_ADD, 10'd1023, 16'h5555);
		send_word(2'd3, 10'h3FF, 16'hAAAA);
		send_word(OP_ADD, 10'd50, 16'h00AA);
		send_word(OP_RUN, 10'h2AA, 16'h5555);
		drain();
		write_reg(CFG_LAST, 10'd1023);
		write_reg(CFG_HEAD, 10'd100);
		write_reg(CFG_MODE, TRK_W'(MODE_SSTF));
		send_word(OP_ADD, 10'd1023, 16'hFFFF);
		send_word(OP_ADD, 10'd150, 16'd3);
		send_word(OP_ADD, 10'd50, 16'd4);
		send_word(OP_RUN, 10'd0, 16'd0);
		drain();
		write_reg(CFG_MODE, TRK_W'(MODE_SCAN));
		write_reg(CFG_LAST, 10'd40);
		write_reg(CFG_HEAD, 10'd900);
		send_word(OP_RUN, 10'd0, 16'd0);
		drain();
		write_reg(CFG_MODE, 10'd3);
		send_word(OP_RUN, 10'd0, 16'd0);
		send_word(OP_CLEAR, 10'd0, 16'd0);
		send_word(OP_RUN, 10'd0, 16'd0);
		drain();

		// full table, then a long receiver hold-off while adds keep coming
		idle_on = 1'b1;
		write_reg(CFG_LAST, 10'd1023);
		write_reg(CFG_MODE, TRK_W'(MODE_SCAN));
		hold_cycles = 300;
		for (int i = 0; i < QUEUE_DEPTH + 2; i++)
			send_word(OP_ADD, TRK_W'($urandom), PID_W'($urandom));
		send_word(OP_RUN, 10'd0, 16'd0);
		drain();

		// random batches across settings, sender pauses between them
		while (words_sent < 400) begin
			pick_config();
			for (int b = 0; b < 3; b++)
				batch(($urandom_range(0, 7) == 0) ? $urandom_range(20, 34)
					: $urandom_range(0, 8));
			if ($urandom_range(0, 2) == 0)
				send_word(2'($urandom), TRK_W'($urandom), PID_W'($urandom));
			drain();
		end

		// final stretch with no idling
		idle_on = 1'b0;
		pick_config();
		batch(12);
		batch(5);
		drain();
		repeat (50) @(posedge clk);

		$display("covered %0d request words and %0d result words, %0d service steps",
			words_sent, sb.checked, sb.service_words);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_disk_seek_scheduler: clean");
		else
			$display("tb_disk_seek_scheduler: errors");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("tb_disk_seek_scheduler: errors");
		$finish;
	end

endmodule
